// File: design/bresenham_line_rasterizer_core_assert.svh
// Assertion macros shared by the line rasterizer checkers.
`ifndef BRESENHAM_LINE_RASTERIZER_CORE_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while dis is high.
`define BRL_ASSERT_IMP(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while dis is high.
`define BRL_ASSERT_NXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/brl_pkg.sv
// Shared types and constants for the Bresenham line rasterizer.
package brl_pkg;

  localparam int COORD_W   = 6;
  localparam int GRID_SIZE = 64;
  localparam int ERR_W     = 8;

  typedef logic [COORD_W-1:0] coord_t;

  // One classified line command as it travels from the front end to the stepper.
  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    coord_t dx;
    coord_t ady;
    logic   sx;
    logic   sy;
  } cmd_t;

endpackage

// File: design/brl_front.sv
// Front end: clamps the endpoints and works out spans and step directions.
module brl_front
  import brl_pkg::*;
#(
  parameter int GRID = GRID_SIZE
)
(
  input  logic [23:0] cmd_data,
  output cmd_t        cmd
);

  localparam coord_t COORD_MAX = COORD_W'(GRID - 1);

  coord_t x0, y0, x1, y1;

  function automatic coord_t clamp_coord(input coord_t v);
    clamp_coord = (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  always_comb begin
    x0 = clamp_coord(cmd_data[5:0]);
    y0 = clamp_coord(cmd_data[11:6]);
    x1 = clamp_coord(cmd_data[17:12]);
    y1 = clamp_coord(cmd_data[23:18]);
    cmd.x0  = x0;
    cmd.y0  = y0;
    cmd.x1  = x1;
    cmd.y1  = y1;
    cmd.dx  = (x1 > x0) ? (x1 - x0) : (x0 - x1);
    cmd.ady = (y1 > y0) ? (y1 - y0) : (y0 - y1);
    cmd.sx  = (x0 < x1);
    cmd.sy  = (y0 < y1);
  end

endmodule

// File: design/brl_cmd_queue.sv
// Two-entry command queue between the front end and the stepper.
module brl_cmd_queue
  import brl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t head
);

  cmd_t       slot0;
  cmd_t       slot1;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b11: begin
          if (count == 2'd1) begin
            slot0 <= push_cmd;
          end else begin
            slot0 <= slot1;
            slot1 <= push_cmd;
          end
        end
        2'b10: begin
          if (count == 2'd0) begin
            slot0 <= push_cmd;
          end else begin
            slot1 <= push_cmd;
          end
          count <= count + 2'd1;
        end
        2'b01: begin
          slot0 <= slot1;
          count <= count - 2'd1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: design/brl_stepper.sv
// Back end: walks the Bresenham line one pixel per cycle into an output register, while not stalled.
module brl_stepper
  import brl_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   cmd_valid,
  input  cmd_t   cmd,
  output logic   cmd_pop,
  output logic   out_valid,
  input  logic   out_ready,
  output coord_t out_x,
  output coord_t out_y,
  output logic   out_last
);

  logic                    busy;
  coord_t                  cur_x, cur_y, tgt_x, tgt_y, span_x, span_y;
  logic                    dir_x, dir_y;
  logic signed [ERR_W-1:0] step_error;

  logic                    advance;
  logic                    done;
  logic signed [ERR_W:0]   e2, dx_s, ady_s, err_sum;
  logic                    step_x, step_y;

  assign advance = busy && (!out_valid || out_ready);
  assign cmd_pop = !busy && cmd_valid;
  assign done    = (cur_x == tgt_x) && (cur_y == tgt_y);

  always_comb begin
    e2      = {step_error, 1'b0};
    dx_s    = $signed({{(ERR_W+1-COORD_W){1'b0}}, span_x});
    ady_s   = $signed({{(ERR_W+1-COORD_W){1'b0}}, span_y});
    step_x  = (e2 >= -ady_s);
    step_y  = (e2 <= dx_s);
    err_sum = {step_error[ERR_W-1], step_error}
              - (step_x ? ady_s : '0) + (step_y ? dx_s : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      out_valid  <= 1'b0;
      cur_x      <= '0;
      cur_y      <= '0;
      tgt_x      <= '0;
      tgt_y      <= '0;
      span_x     <= '0;
      span_y     <= '0;
      dir_x      <= 1'b0;
      dir_y      <= 1'b0;
      step_error <= '0;
    end else begin
      if (out_valid && out_ready && !advance) begin
        out_valid <= 1'b0;
      end
      if (cmd_pop) begin
        busy       <= 1'b1;
        cur_x      <= cmd.x0;
        cur_y      <= cmd.y0;
        tgt_x      <= cmd.x1;
        tgt_y      <= cmd.y1;
        span_x     <= cmd.dx;
        span_y     <= cmd.ady;
        dir_x      <= cmd.sx;
        dir_y      <= cmd.sy;
        step_error <= ERR_W'({2'b00, cmd.dx}) - ERR_W'({2'b00, cmd.ady});
      end else if (advance) begin
        out_valid <= 1'b1;
        out_x     <= cur_x;
        out_y     <= cur_y;
        out_last  <= done;
        if (done) begin
          busy <= 1'b0;
        end else begin
          step_error <= err_sum[ERR_W-1:0];
          if (step_x) begin
            cur_x <= dir_x ? (cur_x + 1'b1) : (cur_x - 1'b1);
          end
          if (step_y) begin
            cur_y <= dir_y ? (cur_y + 1'b1) : (cur_y - 1'b1);
          end
        end
      end
    end
  end

endmodule

// File: design/bresenham_line_rasterizer_core.sv
// Bresenham line rasterizer top level: front end, command queue and stepper.
// A command passes through the queue and the stepper's line registers before its
// first pixel reaches the output register. A line of N pixels (N = max(|dx|,|dy|)+1,
// at most 64) is loaded, then drawn one pixel per cycle unless the output stalls.
// The queue holds two commands, so input is taken while the stepper is drawing.
// Reset (rst, synchronous) empties the queue, idles the stepper, clears inverse_mode.
module bresenham_line_rasterizer_core
  import brl_pkg::*;
#(
  parameter int GRID = GRID_SIZE
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,     // inverse_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // start_x, start_y, end_x, end_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,    // pixel_x, pixel_y, pixel_on, 3 zero bits
  output logic        m_axis_tlast     // last_pixel
);

  logic   inverse_mode;
  cmd_t   front_cmd;
  cmd_t   head_cmd;
  logic   q_full;
  logic   q_not_empty;
  logic   q_pop;
  coord_t pixel_x, pixel_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      inverse_mode <= cfg_wr_data;
    end
  end

  assign s_axis_tready = !q_full;

  brl_front #(
    .GRID (GRID)
  ) u_front (
    .cmd_data (s_axis_tdata),
    .cmd      (front_cmd)
  );

  brl_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_axis_tvalid && s_axis_tready),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_cmd)
  );

  brl_stepper u_stepper (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_not_empty),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_x     (pixel_x),
    .out_y     (pixel_y),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, ~inverse_mode, pixel_y, pixel_x};

endmodule

// File: design/brl_checker.sv
// Port-level checker for the line rasterizer, bound to the top level.
`include "bresenham_line_rasterizer_core_assert.svh"

module brl_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_wr_en,
  input logic        cfg_wr_data,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic       inv_shadow;
  logic       in_run;
  logic [6:0] prev_x, prev_y, cur_x, cur_y;
  logic       near_x, near_y, moved;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_shadow <= 1'b0;
      in_run     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        inv_shadow <= cfg_wr_data;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        in_run <= !m_axis_tlast;
        prev_x <= cur_x;
        prev_y <= cur_y;
      end
    end
  end

  always_comb begin
    cur_x  = {1'b0, m_axis_tdata[5:0]};
    cur_y  = {1'b0, m_axis_tdata[11:6]};
    near_x = (cur_x == prev_x) || (cur_x == prev_x + 7'd1) || (prev_x == cur_x + 7'd1);
    near_y = (cur_y == prev_y) || (cur_y == prev_y + 7'd1) || (prev_y == cur_y + 7'd1);
    moved  = (cur_x != prev_x) || (cur_y != prev_y);
  end

  `BRL_ASSERT_NXT(a_reset_idle, clk, 1'b0, rst, !m_axis_tvalid,
                  "output valid after reset")

  `BRL_ASSERT_NXT(a_stall_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
                  m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
                  "stalled pixel changed")

  `BRL_ASSERT_IMP(a_pixel_on, clk, rst, m_axis_tvalid, m_axis_tdata[12] == !inv_shadow,
                  "pixel_on does not follow inverse mode")

  `BRL_ASSERT_IMP(a_step_adjacent, clk, rst, m_axis_tvalid && in_run,
                  near_x && near_y && moved,
                  "pixel is not a single step from the previous one")

endmodule

bind bresenham_line_rasterizer_core brl_checker u_brl_checker (
  .clk           (clk),
  .rst           (rst),
  .cfg_wr_en     (cfg_wr_en),
  .cfg_wr_data   (cfg_wr_data),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
